// ----- rtl/convex_min_plus_merge_top_defines.svh -----
// Assertion macros shared by the checker of convex_min_plus_merge_top.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef CONVEX_MIN_PLUS_MERGE_TOP_DEFINES_SVH
`define CONVEX_MIN_PLUS_MERGE_TOP_DEFINES_SVH

// same-cycle implication
`define CMP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/convmp_pkg.sv -----
// Package of convex_min_plus_merge: widths, infinity constant, action codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package convmp_pkg;
  localparam int VW = 61;
  localparam int SW = 62;
  localparam logic [VW-1:0] INF = {1'b1, 60'b0};
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_MERGE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;
  typedef logic [VW-1:0] cost_t;
endpackage
`default_nettype wire

// ----- rtl/convex_min_plus_merge_top.sv -----
// Top level of convex_min_plus_merge: sequencer, shared adder/compare, tables.
// Depends on convmp_pkg and convmp_ram.
//
// Use: items enter on in_valid/in_ready with fields action, index, value,
// lin_cost, quad_cost. Actions clear and load finish as they are accepted.
// A read steps through RD_ISS and RD_DAT, then registers read_value and
// is_infinite on out_valid/out_ready; the result sits in an output register,
// so the next item is taken while it waits. A merge runs a shift pass (one
// succ/acc RAM read, then one write per entry) and, when the accumulator
// holds data, a convolution paced by one read port per table and the single
// shared compare. p is count_p clamped to 1..P_MAX. in_ready is low while a
// merge or read is at work.
// count_p is written on cfg_valid/cfg_ready, always ready; write it only
// when idle. Reset marks the accumulator empty and sets count_p to 1; table
// contents are not cleared. A stalled receiver holds the result and blocks a
// further read from finishing until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module convex_min_plus_merge_top #(
  parameter int P_MAX = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           action,
  input  wire logic [10:0]          index,
  input  wire logic [60:0]          value,
  input  wire logic [19:0]          lin_cost,
  input  wire logic [19:0]          quad_cost,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output convmp_pkg::cost_t         read_value,
  output logic                      is_infinite,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [10:0]          count_p
);
  import convmp_pkg::*;

  localparam int AW = $clog2(P_MAX + 1);
  localparam int JW = $clog2(P_MAX + 2);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SH_RD  = 4'd1;
  localparam logic [3:0] S_SH_WR  = 4'd2;
  localparam logic [3:0] S_CV_I0  = 4'd3;
  localparam logic [3:0] S_CV_I1  = 4'd4;
  localparam logic [3:0] S_CV_RD0 = 4'd5;
  localparam logic [3:0] S_CV_RD1 = 4'd6;
  localparam logic [3:0] S_CV_RD2 = 4'd7;
  localparam logic [3:0] S_CV_CMP = 4'd8;
  localparam logic [3:0] S_RD_ISS = 4'd9;
  localparam logic [3:0] S_RD_DAT = 4'd10;

  logic [3:0]    state;
  logic [10:0]   cnt;
  logic          acc_valid;
  logic [JW-1:0] j, a;
  logic [19:0]   lin_r, quad_r;
  logic [SW-1:0] edge_r, dq;
  cost_t         x0, y0;
  logic [10:0]   idx_r;

  logic [JW-1:0] p_eff, am1;
  logic [SW-1:0] e_next, sh_sum, lhs, rhs;
  cost_t         sh_val, res_val, rd_val;
  logic          cond, in_fire, load_ok, rd_hit;

  logic          succ_we, shf_we, old_we, acc_we;
  logic [AW-1:0] succ_wa, shf_wa, old_wa, acc_wa;
  logic [AW-1:0] succ_ra, shf_ra, old_ra, acc_ra;
  cost_t         succ_wd, shf_wd, old_wd, acc_wd;
  cost_t         succ_rd, shf_rd, old_rd, acc_rd;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    if (cnt == 11'd0) begin
      p_eff = JW'(1);
    end else if (32'(cnt) > 32'(P_MAX)) begin
      p_eff = JW'(P_MAX);
    end else begin
      p_eff = JW'(cnt);
    end
  end

  assign am1     = a + JW'(1);
  assign e_next  = edge_r + SW'(lin_r) + dq;
  assign sh_sum  = SW'(succ_rd) + e_next;
  assign sh_val  = (j == '0) ? INF :
                   ((sh_sum > SW'(INF)) ? INF : sh_sum[VW-1:0]);
  assign lhs     = SW'(x0) + SW'(y0);
  assign rhs     = SW'(old_rd) + SW'(shf_rd);
  assign cond    = (am1 <= j) && (y0 < INF) && (lhs > rhs);
  assign res_val = (lhs > SW'(INF)) ? INF : lhs[VW-1:0];
  assign load_ok = 32'(index) <= 32'(P_MAX);
  assign rd_hit  = acc_valid && (32'(idx_r) <= 32'(p_eff));
  assign rd_val  = (!rd_hit || acc_rd > INF) ? INF : acc_rd;

  always_comb begin
    succ_we = in_fire && (action == ACT_LOAD) && load_ok;
    succ_wa = AW'(index);
    succ_wd = (value > INF) ? INF : value;
    succ_ra = AW'(j);

    shf_we = (state == S_SH_WR);
    shf_wa = AW'(j);
    shf_wd = sh_val;
    shf_ra = (state == S_CV_RD0) ? AW'(j - a) : AW'(j - am1);

    old_we = (state == S_SH_WR) && acc_valid;
    old_wa = AW'(j);
    old_wd = acc_rd;
    old_ra = (state == S_CV_RD0) ? AW'(a) : AW'(am1);

    acc_ra = (state == S_SH_RD) ? AW'(j) : AW'(idx_r);
    acc_we = 1'b0;
    acc_wa = AW'(j);
    acc_wd = res_val;
    case (state)
      S_SH_WR: begin
        acc_we = !acc_valid;
        acc_wd = sh_val;
      end
      S_CV_I0: begin
        acc_we = 1'b1;
        acc_wa = AW'(0);
        acc_wd = INF;
      end
      S_CV_I1: begin
        acc_we = 1'b1;
        acc_wa = AW'(1);
        acc_wd = INF;
      end
      S_CV_CMP: begin
        acc_we = !cond;
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 11'd1;
      acc_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cnt <= count_p;
      end
      if (out_valid && out_ready && (state != S_RD_DAT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            idx_r  <= index;
            lin_r  <= lin_cost;
            quad_r <= quad_cost;
            j      <= '0;
            edge_r <= '0;
            dq     <= '0;
            case (action)
              ACT_CLEAR: acc_valid <= 1'b0;
              ACT_MERGE: state <= S_SH_RD;
              ACT_READ:  state <= S_RD_ISS;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          if (j != '0) begin
            edge_r <= e_next;
            dq     <= dq + SW'(quad_r);
          end
          if (j == p_eff) begin
            if (!acc_valid) begin
              acc_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_CV_I0;
            end
          end else begin
            j     <= j + JW'(1);
            state <= S_SH_RD;
          end
        end
        S_CV_I0: begin
          state <= S_CV_I1;
        end
        S_CV_I1: begin
          j <= JW'(2);
          a <= JW'(1);
          state <= (p_eff == JW'(1)) ? S_IDLE : S_CV_RD0;
        end
        S_CV_RD0: begin
          state <= S_CV_RD1;
        end
        S_CV_RD1: begin
          x0    <= old_rd;
          y0    <= shf_rd;
          state <= S_CV_CMP;
        end
        S_CV_RD2: begin
          state <= S_CV_CMP;
        end
        S_CV_CMP: begin
          if (cond) begin
            a     <= am1;
            x0    <= old_rd;
            y0    <= shf_rd;
            state <= S_CV_RD2;
          end else if (j == p_eff) begin
            state <= S_IDLE;
          end else begin
            j     <= j + JW'(1);
            state <= S_CV_RD0;
          end
        end
        S_RD_ISS: begin
          state <= S_RD_DAT;
        end
        S_RD_DAT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            read_value  <= rd_val;
            is_infinite <= (rd_val >= INF);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  convmp_ram #(.W(VW), .DEPTH(P_MAX + 1)) u_succ (
    .clk(clk), .we(succ_we), .waddr(succ_wa), .wdata(succ_wd),
    .raddr(succ_ra), .rdata(succ_rd)
  );
  convmp_ram #(.W(VW), .DEPTH(P_MAX + 1)) u_shf (
    .clk(clk), .we(shf_we), .waddr(shf_wa), .wdata(shf_wd),
    .raddr(shf_ra), .rdata(shf_rd)
  );
  convmp_ram #(.W(VW), .DEPTH(P_MAX + 1)) u_old (
    .clk(clk), .we(old_we), .waddr(old_wa), .wdata(old_wd),
    .raddr(old_ra), .rdata(old_rd)
  );
  convmp_ram #(.W(VW), .DEPTH(P_MAX + 1)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_wa), .wdata(acc_wd),
    .raddr(acc_ra), .rdata(acc_rd)
  );
endmodule
`default_nettype wire

// ----- rtl/convmp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module convmp_ram #(
  parameter int W = 61,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/convmp_checker.sv -----
// Port-level checker of convex_min_plus_merge_top, bound to the top level.
// Depends on convmp_pkg and convex_min_plus_merge_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "convex_min_plus_merge_top_defines.svh"
module convmp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [1:0]        action,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire convmp_pkg::cost_t read_value,
  input wire logic              is_infinite
);
  import convmp_pkg::*;

  // hold a stalled result
  `CMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value))
  // a read transaction keeps the block busy
  `CMP_ASSERT_NEXT(a_read_busy, in_valid && in_ready && action == ACT_READ, !in_ready)
  // results are saturated and flagged consistently
  `CMP_ASSERT_NOW(a_sat_flag, out_valid, read_value <= INF && is_infinite == (read_value == INF))
endmodule

bind convex_min_plus_merge_top convmp_checker u_chk (.*);
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for convex_min_plus_merge_top: directed table, then random traffic;
// reads match fixed values or an in-bench merge predictor. Depends on convmp_pkg.
`timescale 1ns / 1ps
module testbench;
  import convmp_pkg::*;

  localparam int PMAX = 1024;
  localparam logic [63:0] INF64 = 64'd1 << 60;

  typedef struct {
    logic [1:0]  act;
    logic [10:0] idx;
    logic [60:0] val;
    logic [19:0] lin;
    logic [19:0] quad;
    bit          fixed;
    logic [60:0] ev;
    bit          einf;
  } row_t;

  typedef struct {
    cost_t v;
    bit    inf;
  } rd_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  action = ACT_CLEAR;
  logic [10:0] index = 0;
  logic [60:0] value = 0;
  logic [19:0] lin_cost = 0;
  logic [19:0] quad_cost = 0;
  logic        out_valid;
  logic        out_ready = 0;
  cost_t       read_value;
  logic        is_infinite;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [10:0] count_p = 0;

  convex_min_plus_merge_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .index(index), .value(value), .lin_cost(lin_cost), .quad_cost(quad_cost),
    .out_valid(out_valid), .out_ready(out_ready), .read_value(read_value),
    .is_infinite(is_infinite), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .count_p(count_p)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] acc_cost [0:PMAX];
  logic [63:0] succ_cost [0:PMAX];
  logic [63:0] shifted_cost [0:PMAX];
  logic [63:0] prev_acc [0:PMAX];
  bit          acc_wr [0:PMAX];
  bit          succ_wr [0:PMAX];
  bit          acc_full;
  int          units = 1;

  rd_t reads_pending [$];
  int  errors = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  logic rx_hold = 0;

  function automatic logic [63:0] sat(logic [63:0] x);
    return (x > INF64) ? INF64 : x;
  endfunction

  function automatic void merge_tables(logic [63:0] lin, logic [63:0] quad);
    logic [63:0] jj;
    int a;
    shifted_cost[0] = INF64;
    for (int j = 1; j <= units; j++) begin
      jj = 64'(j);
      shifted_cost[j] = sat(succ_cost[j] + lin * jj + quad * ((jj * (jj - 1)) / 2));
    end
    if (!acc_full) begin
      for (int j = 0; j <= units; j++) begin
        acc_cost[j] = shifted_cost[j];
        acc_wr[j] = 1;
      end
      acc_full = 1;
      return;
    end
    for (int j = 0; j <= units; j++) prev_acc[j] = acc_cost[j];
    a = 1;
    acc_cost[0] = INF64;
    acc_cost[1] = INF64;
    for (int j = 2; j <= units; j++) begin
      while (a + 1 <= j && shifted_cost[j - a] < INF64 &&
             prev_acc[a] + shifted_cost[j - a] > prev_acc[a + 1] + shifted_cost[j - a - 1])
        a++;
      acc_cost[j] = sat(prev_acc[a] + shifted_cost[j - a]);
    end
  endfunction

  function automatic rd_t predict_read(logic [10:0] idx);
    rd_t r;
    logic [63:0] c;
    c = INF64;
    if (acc_full && idx <= units) c = sat(acc_cost[idx]);
    r.v = c[60:0];
    r.inf = (c >= INF64);
    return r;
  endfunction

  task automatic send(row_t r);
    rd_t e;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    action <= r.act;
    index <= r.idx;
    value <= r.val;
    lin_cost <= r.lin;
    quad_cost <= r.quad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (r.act)
      ACT_CLEAR: acc_full = 0;
      ACT_LOAD: begin
        if (r.idx <= PMAX) begin
          succ_cost[r.idx] = sat({3'b0, r.val});
          succ_wr[r.idx] = 1;
        end
      end
      ACT_MERGE: merge_tables(64'(r.lin), 64'(r.quad));
      default: begin
        if (r.fixed) begin
          e.v = r.ev;
          e.inf = r.einf;
        end else begin
          e = predict_read(r.idx);
        end
        reads_pending = {reads_pending, e};
      end
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    while (reads_pending.size() != 0) @(posedge clk);
    repeat (7 * units + 40) @(posedge clk);
  endtask

  task automatic write_count(logic [10:0] c);
    drain();
    cfg_valid <= 1;
    count_p <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    units = (c < 1) ? 1 : (c > PMAX) ? PMAX : int'(c);
  endtask

  function automatic row_t mk(logic [1:0] act, logic [10:0] idx, logic [60:0] val,
                              logic [19:0] lin, logic [19:0] quad);
    row_t r;
    r = '{act: act, idx: idx, val: val, lin: lin, quad: quad, fixed: 0, ev: 0, einf: 0};
    return r;
  endfunction

  function automatic logic [60:0] rand_cost();
    case ($urandom_range(9))
      0: return INF;
      1: return 61'({$urandom, $urandom});
      2: return 61'h1fff_ffff_ffff_ffff;
      default: return 61'($urandom_range(1 << 20));
    endcase
  endfunction

  task automatic random_item();
    int pick;
    logic [10:0] idx;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send(mk(ACT_CLEAR, 11'($urandom), 61'({$urandom, $urandom}), 20'($urandom),
              20'($urandom)));
    end else if (pick < 45) begin
      idx = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(units));
      send(mk(ACT_LOAD, idx, rand_cost(), 20'($urandom), 20'($urandom)));
    end else if (pick < 62 && units <= 100) begin
      for (int j = 1; j <= units; j++)
        if (!succ_wr[j]) send(mk(ACT_LOAD, 11'(j), 61'($urandom_range(1 << 16)),
                                 20'd0, 20'd0));
      if (acc_full)
        for (int j = 1; j <= units; j++)
          if (!acc_wr[j]) begin
            send(mk(ACT_CLEAR, 11'd0, 61'd0, 20'd0, 20'd0));
            break;
          end
      send(mk(ACT_MERGE, 11'($urandom), 61'({$urandom, $urandom}),
              ($urandom_range(7) == 0) ? 20'hfffff : 20'($urandom_range(1 << 12)),
              ($urandom_range(7) == 0) ? 20'hfffff : 20'($urandom_range(1 << 8))));
    end else begin
      idx = ($urandom_range(7) == 0) ? 11'($urandom) : 11'($urandom_range(units + 2));
      if (acc_full && idx <= units && !acc_wr[idx]) idx = 11'(units + 1);
      send(mk(ACT_READ, idx, 61'({$urandom, $urandom}), 20'($urandom), 20'($urandom)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (rx_hold) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    rd_t e;
    if (!rst && out_valid && out_ready) begin
      if (reads_pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read result %h inf %b", read_value, is_infinite);
      end else begin
        e = reads_pending.pop_front();
        if (read_value !== e.v || is_infinite !== e.inf) begin
          errors++;
          if (errors <= 10)
            $display("read mismatch: expected %h inf %b, got %h inf %b",
                     e.v, e.inf, read_value, is_infinite);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  row_t dir_rows [15];
  logic [10:0] counts [8] = '{11'd2047, 11'd0, 11'd5, 11'd3, 11'd17, 11'd2, 11'd64, 11'd8};

  initial begin
    logic [10:0] ridx;
    dir_rows = '{
      '{ACT_READ, 11'd0, 61'd0, 20'd0, 20'd0, 1, INF, 1},
      '{ACT_READ, 11'd2047, 61'h1fff_ffff_ffff_ffff, 20'hfffff, 20'hfffff, 1, INF, 1},
      '{ACT_LOAD, 11'd0, 61'd0, 20'd0, 20'd0, 0, 0, 0},
      '{ACT_LOAD, 11'd1, 61'h1fff_ffff_ffff_ffff, 20'd0, 20'd0, 0, 0, 0},
      '{ACT_LOAD, 11'd2047, 61'd5, 20'd0, 20'd0, 0, 0, 0},
      '{ACT_MERGE, 11'd0, 61'd0, 20'd0, 20'd0, 0, 0, 0},
      '{ACT_READ, 11'd1, 61'd0, 20'd0, 20'd0, 1, INF, 1},
      '{ACT_LOAD, 11'd1, 61'd7, 20'd0, 20'd0, 0, 0, 0},
      '{ACT_CLEAR, 11'd0, 61'd0, 20'd0, 20'd0, 0, 0, 0},
      '{ACT_MERGE, 11'd0, 61'd0, 20'hfffff, 20'hfffff, 0, 0, 0},
      '{ACT_READ, 11'd0, 61'd0, 20'd0, 20'd0, 1, INF, 1},
      '{ACT_READ, 11'd1, 61'd0, 20'd0, 20'd0, 0, 0, 0},
      '{ACT_READ, 11'd2, 61'd0, 20'd0, 20'd0, 1, INF, 1},
      '{ACT_MERGE, 11'd0, 61'd0, 20'd0, 20'd0, 0, 0, 0},
      '{ACT_READ, 11'd1, 61'd0, 20'd0, 20'd0, 1, INF, 1}
    };
    for (int j = 0; j <= PMAX; j++) begin
      acc_wr[j] = 0;
      succ_wr[j] = 0;
    end
    acc_full = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_rows[k]) send(dir_rows[k]);
    for (int ph = 0; ph < 8; ph++) begin
      tx_idle_pct = (ph < 3) ? 28 : (ph < 6) ? 83 : 0;
      rx_idle_pct = (ph < 3) ? 83 : (ph < 6) ? 28 : 0;
      write_count(counts[ph]);
      for (int n = 0; n < ((units > 100) ? 10 : 30); n++) random_item();
      if (ph == 7) begin
        rx_hold <= 1;
        fork
          begin
            repeat (400) @(posedge clk);
            rx_hold <= 0;
          end
        join_none
        for (int n = 0; n < 12; n++) begin
          ridx = 11'($urandom_range(units + 1));
          if (acc_full && ridx <= units && !acc_wr[ridx]) ridx = 11'(units + 1);
          send(mk(ACT_READ, ridx, 61'd0, 20'd0, 20'd0));
        end
      end
    end
    drain();
    if (errors == 0 && reads_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
